### rtl/tmidl_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed-mean duty loop package
// Shared widths, register indexes, fixed-point constants and the request
// type of the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tmidl_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Percent in Q7.16: 100.0 is 100 * 2^16.
    localparam int PCT_W = 23;
    localparam logic [PCT_W-1:0] PCT_FULL = 23'd6553600;

    // |target - mean| * 100 * 2^16 needs 12 + 7 + 16 bits.
    localparam int AD100_W   = SAMPLE_W + 7;
    localparam int ERR_NUM_W = AD100_W + 16;

    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_DARK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] bits;
    } t_div_req;

endpackage

`default_nettype wire

### rtl/tmidl_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Takes a left-aligned dividend one bit per cycle, MSB first, and shifts in
// one quotient bit per cycle. Pulses o_done when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tmidl_div
    import tmidl_pkg::*;
#(
    parameter int NUM_W = 39,
    parameter int DEN_W = 23,
    parameter int QUO_W = 23
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [QUO_W-1:0] o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] trial_sub;
    logic           ge;

    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign ge        = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.bits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

### rtl/trimmed_mean_integral_duty_loop.sv
// ----------------------------------------------------------------------------
// Trimmed-mean integral duty loop
// Channel    | Direction | Contents
// s_axis     | in        | tdata[11:0] sensor_sample
// m_axis     | out       | tdata[11:0] pwm_duty, tdata[23:12] filtered_level,
//            |           | tuser[0] apply_duty
// cfg        | in        | 0 dark, 1 bright, 2 target (clears duty), 3 enable
//
// Min, max and sum are kept as samples arrive. The last sample of a group
// starts a sequence set by the bit-serial divider (mean, error and PWM
// scaling) and the bit-serial multiply by SAMPLE_MAX; it is shorter when the
// error is zero or saturated. No samples are taken during that sequence.
// Reset is synchronous. A stalled result is held in the output register while
// the next group is taken; the next result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_integral_duty_loop
    import tmidl_pkg::*;
#(
    parameter int GROUP_SIZE = 4,
    parameter int SAMPLE_MAX = 4095
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,  // [11:0] sensor_sample
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [23:0]          m_axis_tdata,  // [11:0] pwm_duty, [23:12] filtered_level
    output logic      [0:0]           m_axis_tuser,  // [0] apply_duty
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int SMAX_W = $clog2(SAMPLE_MAX + 1);
    localparam int GRP_W  = $clog2(GROUP_SIZE);
    localparam int SUM_W  = SAMPLE_W + $clog2(GROUP_SIZE);
    localparam int PROD_W = PCT_W + SMAX_W;
    localparam int NUM_W  = (PROD_W > ERR_NUM_W) ? PROD_W : ERR_NUM_W;
    localparam int MCNT_W = $clog2(SMAX_W + 1);

    localparam logic [GRP_W-1:0] LAST_POS = GRP_W'(GROUP_SIZE - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRIM  = 4'd1;
    localparam logic [3:0] S_MEAN  = 4'd2;
    localparam logic [3:0] S_MEANW = 4'd3;
    localparam logic [3:0] S_ERR   = 4'd4;
    localparam logic [3:0] S_ERRD  = 4'd5;
    localparam logic [3:0] S_ERRW  = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_PWM   = 4'd9;
    localparam logic [3:0] S_PWMW  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0] r_state;

    logic [CFG_W-1:0] r_dark;
    logic [CFG_W-1:0] r_bright;
    logic [CFG_W-1:0] r_target;
    logic             r_drive;

    logic [GRP_W-1:0]    r_pos;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_lo;
    logic [SAMPLE_W-1:0] r_hi;
    logic                r_same;
    logic [SAMPLE_W-1:0] r_mean;
    logic [SAMPLE_W-1:0] r_ad;
    logic [SAMPLE_W-1:0] r_as;
    logic                r_dneg;
    logic                r_sneg;
    logic                r_neg;
    logic [PCT_W-1:0]    r_mag;
    logic [PCT_W-1:0]    r_acc;
    logic [PROD_W-1:0]   r_prod;
    logic [SMAX_W-1:0]   r_mbits;
    logic [MCNT_W-1:0]   r_mcnt;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_pwm;
    logic [SAMPLE_W-1:0] r_out_level;
    logic                r_out_apply;

    logic                in_hs;
    logic                first;
    logic [SAMPLE_W-1:0] s_in;
    logic [SAMPLE_W-1:0] s_sat;
    logic [SUM_W-1:0]    n_sum;
    logic [SAMPLE_W-1:0] n_lo;
    logic [SAMPLE_W-1:0] n_hi;
    logic [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]   span;
    logic [AD100_W-1:0]  ad100;
    logic [PCT_W:0]      acc_add;
    logic [PCT_W-1:0]    n_acc;

    t_div_req          div_req;
    logic [NUM_W-1:0]  div_num;
    logic [PCT_W-1:0]  div_den;
    logic              div_done;
    logic [PCT_W-1:0]  div_quo;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_hs         = s_axis_tvalid && s_axis_tready;

    assign s_in  = s_axis_tdata[SAMPLE_W-1:0];
    assign s_sat = ({20'd0, s_in} > 32'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : s_in;
    assign first = (r_pos == '0);
    assign n_sum = first ? SUM_W'(s_sat) : r_sum + SUM_W'(s_sat);
    assign n_lo  = (first || (s_sat < r_lo)) ? s_sat : r_lo;
    assign n_hi  = (first || (s_sat > r_hi)) ? s_sat : r_hi;

    assign diff  = {1'b0, r_target} - {1'b0, r_mean};
    assign span  = {1'b0, r_bright} - {1'b0, r_dark};
    assign ad100 = AD100_W'(r_ad) * AD100_W'(100);

    assign acc_add = {1'b0, r_acc} + {1'b0, r_mag};

    always_comb begin
        if (r_neg) begin
            n_acc = (r_mag > r_acc) ? '0 : r_acc - r_mag;
        end else begin
            n_acc = (acc_add > {1'b0, PCT_FULL}) ? PCT_FULL : acc_add[PCT_W-1:0];
        end
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.bits  = '0;
        div_num       = '0;
        div_den       = '0;
        unique case (r_state)
            S_MEAN: begin
                div_req.start = 1'b1;
                div_req.bits  = DIV_CNT_W'(SUM_W);
                div_num       = NUM_W'(r_sum) << (NUM_W - SUM_W);
                div_den       = r_same ? PCT_W'(GROUP_SIZE - 1) : PCT_W'(GROUP_SIZE - 2);
            end
            S_ERRD: begin
                div_req.start = (r_ad != '0) && (r_as != '0) && (r_ad < r_as);
                div_req.bits  = DIV_CNT_W'(ERR_NUM_W);
                div_num       = NUM_W'({ad100, 16'd0}) << (NUM_W - ERR_NUM_W);
                div_den       = PCT_W'(r_as);
            end
            S_PWM: begin
                div_req.start = 1'b1;
                div_req.bits  = DIV_CNT_W'(PROD_W);
                div_num       = NUM_W'(r_prod) << (NUM_W - PROD_W);
                div_den       = PCT_FULL;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    tmidl_div #(
        .NUM_W (NUM_W),
        .DEN_W (PCT_W),
        .QUO_W (PCT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark   <= '0;
            r_bright <= CFG_W'(4095);
            r_target <= '0;
            r_drive  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_DARK:   r_dark   <= i_cfg_wdata;
                REG_BRIGHT: r_bright <= i_cfg_wdata;
                REG_TARGET: r_target <= i_cfg_wdata;
                REG_DRIVE:  r_drive  <= i_cfg_wdata[0];
                default:    r_drive  <= r_drive;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ACC) begin
                r_acc <= n_acc;
            end else if (i_cfg_wr_en && (i_cfg_index == REG_TARGET)) begin
                r_acc <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_hs) begin
                        if (r_pos == LAST_POS) begin
                            r_pos   <= '0;
                            r_state <= S_TRIM;
                        end else begin
                            r_pos <= r_pos + GRP_W'(1);
                        end
                    end
                end
                S_TRIM:  r_state <= S_MEAN;
                S_MEAN:  r_state <= S_MEANW;
                S_MEANW: begin
                    if (div_done) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR:   r_state <= S_ERRD;
                S_ERRD:  r_state <= div_req.start ? S_ERRW : S_ACC;
                S_ERRW: begin
                    if (div_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC:   r_state <= S_MUL;
                S_MUL: begin
                    if (r_mcnt == MCNT_W'(1)) begin
                        r_state <= S_PWM;
                    end
                end
                S_PWM:   r_state <= S_PWMW;
                S_PWMW: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_hs) begin
            r_sum <= n_sum;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
        end
        if (r_state == S_TRIM) begin
            r_sum  <= r_sum - SUM_W'(r_lo) - ((r_lo == r_hi) ? '0 : SUM_W'(r_hi));
            r_same <= (r_lo == r_hi);
        end
        if ((r_state == S_MEANW) && div_done) begin
            r_mean <= div_quo[SAMPLE_W-1:0];
        end
        if (r_state == S_ERR) begin
            r_dneg <= diff[SAMPLE_W];
            r_sneg <= span[SAMPLE_W];
            r_ad   <= diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
            r_as   <= span[SAMPLE_W] ? SAMPLE_W'(-span) : span[SAMPLE_W-1:0];
        end
        if (r_state == S_ERRD) begin
            if (r_ad == '0) begin
                r_mag <= '0;
                r_neg <= 1'b0;
            end else if (r_as == '0) begin
                r_mag <= PCT_FULL;
                r_neg <= r_dneg;
            end else begin
                r_mag <= PCT_FULL;
                r_neg <= r_dneg ^ r_sneg;
            end
        end
        if ((r_state == S_ERRW) && div_done) begin
            r_mag <= div_quo;
        end
        if (r_state == S_ACC) begin
            r_prod  <= '0;
            r_mbits <= SMAX_W'(SAMPLE_MAX);
            r_mcnt  <= MCNT_W'(SMAX_W);
        end
        if (r_state == S_MUL) begin
            r_prod  <= (r_prod << 1) + (r_mbits[SMAX_W-1] ? PROD_W'(r_acc) : '0);
            r_mbits <= r_mbits << 1;
            r_mcnt  <= r_mcnt - MCNT_W'(1);
        end
        if ((r_state == S_EMIT) && (!r_out_valid || m_axis_tready)) begin
            r_out_pwm   <= div_quo[SAMPLE_W-1:0];
            r_out_level <= r_mean;
            r_out_apply <= r_drive;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_level, r_out_pwm};
    assign m_axis_tuser  = r_out_apply;

endmodule

`default_nettype wire

### rtl/tmidl_chk.sv
// ----------------------------------------------------------------------------
// Trimmed-mean duty loop port checker
// Watches the stream ports of the top level over time and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module tmidl_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // A stalled result transaction keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Reset drops any pending result.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // The block is ready for samples right after reset.
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("not ready for samples after reset");

    // A result never appears in the cycle right after a sample transaction.
    a_no_early: assert property (@(posedge i_clk)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

endmodule

bind trimmed_mean_integral_duty_loop tmidl_chk u_tmidl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
